>>> rtl/dht_pkg.sv
`default_nettype none

package dht_pkg;

   // FNV-1a 32-bit constants and the pad byte for short call signs.
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [7:0]  PAD_BYTE  = 8'h20;

   localparam logic [31:0] TTL_RESET = 32'd30000;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_MARK  = 2'd0;
   localparam logic [1:0] MODE_PEEK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam int unsigned COUNT_MAX = 63;

   typedef struct packed {
      logic [1:0]  mode;
      logic [39:0] call_sign;
      logic [15:0] message_id;
      logic [7:0]  fragment_index;
      logic [31:0] now_ms;
   } dht_req_type;

   typedef struct packed {
      logic        seen;
      logic [5:0]  live_count;
      logic [31:0] key_hash;
   } dht_rsp_type;

   typedef struct packed {
      logic        used;
      logic [31:0] hash;
      logic [31:0] stamp;
   } dht_entry_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic load;
   } dht_cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_COMMIT,
      ST_DONE
   } dht_state_type;

endpackage

`default_nettype wire

>>> rtl/dht_cell.sv
`default_nettype none

module dht_cell
   import dht_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dht_cell_ctrl_type ctrl,
   input  wire dht_entry_type     shift_in,
   input  wire dht_entry_type     write_in,
   output dht_entry_type          entry_out
);

   dht_entry_type entry_ff;
   dht_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in = '0;
      end else if (ctrl.load) begin
         entry_in = write_in;
      end else if (ctrl.shift) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.hash  <= entry_in.hash;
      entry_ff.stamp <= entry_in.stamp;
      if (reset) begin
         entry_ff.used <= 1'b0;
      end else begin
         entry_ff.used <= entry_in.used;
      end
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

>>> rtl/dht_hash.sv
`default_nettype none

module dht_hash
   import dht_pkg::*;
#(
   parameter int unsigned CALL_BYTES = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire dht_req_type req,
   output logic             done,
   output logic [31:0]      hash
);

   localparam int unsigned KEY_BYTES = CALL_BYTES + 3;
   localparam int unsigned STEP_W    = $clog2(KEY_BYTES);

   logic [7:0]        key_ff [KEY_BYTES];
   logic [31:0]       hash_ff;
   logic [STEP_W-1:0] step_ff;
   logic              ended_ff;
   logic              busy_ff;
   logic              done_ff;

   logic        in_call;
   logic        ended_in;
   logic [7:0]  key_byte;
   logic [31:0] mixed;
   logic [31:0] product;

   // Call sign bytes end at the first zero byte; the rest become spaces.
   always_comb begin
      in_call  = step_ff < STEP_W'(CALL_BYTES);
      ended_in = ended_ff || (key_ff[0] == 8'd0);
      key_byte = key_ff[0];
      if (in_call && ended_in) begin
         key_byte = PAD_BYTE;
      end
      mixed   = hash_ff ^ {24'd0, key_byte};
      product = mixed * FNV_PRIME;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int j = 0; j < CALL_BYTES; j++) begin
            key_ff[j] <= (j < 5) ? req.call_sign[8*(j%5) +: 8] : 8'd0;
         end
         key_ff[CALL_BYTES]     <= req.message_id[7:0];
         key_ff[CALL_BYTES + 1] <= req.message_id[15:8];
         key_ff[CALL_BYTES + 2] <= req.fragment_index;
         hash_ff                <= FNV_BASIS;
      end else if (busy_ff) begin
         for (int j = 0; j < KEY_BYTES - 1; j++) begin
            key_ff[j] <= key_ff[j + 1];
         end
         key_ff[KEY_BYTES - 1] <= 8'd0;
         hash_ff               <= product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         ended_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            step_ff  <= '0;
            ended_ff <= 1'b0;
         end else if (busy_ff) begin
            ended_ff <= in_call && ended_in;
            step_ff  <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(KEY_BYTES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign hash = hash_ff;

endmodule

`default_nettype wire

>>> rtl/packet_dedup_hash_ttl_table.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_ready    dht_req_type: mode, call sign, id, fragment, time
// rsp_      out        rsp_valid / rsp_ready    dht_rsp_type: seen, live count, key hash
// csr_      in         csr_we (no wait)         csr_wdata: TTL in milliseconds
//
// An item runs from acceptance through the serial hash, the table pass and the
// commit to a result; a clear skips the table pass. The serial hash takes one key
// byte per multiply, and the ring of slot cells rotates one slot past the head cell
// per cycle. Reset is synchronous and marks every slot unused and sets the TTL to
// 30000. A stalled result sits in the output register; the next item is still
// accepted and worked on, and it waits in the last state until the output
// register has been emptied.
`default_nettype none

module packet_dedup_hash_ttl_table
   import dht_pkg::*;
#(
   parameter int unsigned SLOTS      = 32,
   parameter int unsigned CALL_BYTES = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dht_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output dht_rsp_type      rsp_data,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   // State machine and the item that is being worked on.
   dht_state_type state_ff, state_in;
   dht_req_type   req_ff;
   logic [31:0]   ttl_ff;

   // Ring of slot cells. Cell 0 is the head that the scan looks at.
   dht_entry_type     cell_q [SLOTS];
   dht_cell_ctrl_type cell_ctrl [SLOTS];
   dht_entry_type     write_entry;

   // Hash unit.
   logic        hash_start;
   logic        hash_done;
   logic [31:0] key_hash;

   // Scan results, gathered one slot per cycle.
   logic [IDX_W-1:0] scan_idx_ff;
   logic             seen_ff;
   logic             found_exp_ff;
   logic [IDX_W-1:0] exp_idx_ff;
   logic             have_free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [31:0]      old_age_ff;
   logic [IDX_W-1:0] old_idx_ff;
   logic [CNT_W-1:0] live_cnt_ff;

   logic             rsp_valid_ff;
   dht_rsp_type      rsp_ff;

   // FSM outputs.
   logic accept;
   logic scan_en;
   logic commit_en;
   logic rsp_load;

   // Decoded item and head evaluation.
   logic             is_mark;
   logic             is_clear;
   logic [31:0]      head_age;
   logic             head_live;
   logic             head_exp;
   logic             head_hit;
   logic             scan_last;
   logic             do_write;
   logic [IDX_W-1:0] victim;
   logic             victim_live;
   logic [8:0]       count_wide;
   dht_rsp_type      rsp_next;

   assign is_mark  = req_ff.mode == MODE_MARK;
   assign is_clear = req_ff.mode == MODE_CLEAR;

   dht_hash #(
      .CALL_BYTES(CALL_BYTES)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .req  (req_data),
      .done (hash_done),
      .hash (key_hash)
   );

   assign hash_start = accept;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = is_clear ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // FSM outputs.
   always_comb begin
      req_ready = 1'b0;
      scan_en   = 1'b0;
      commit_en = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_en   = 1'b1;
         ST_COMMIT: commit_en = 1'b1;
         ST_DONE:   rsp_load  = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_we) begin
         ttl_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // The head cell holds slot scan_idx_ff during the pass, since the ring moves
   // one place per cycle and starts from its home positions.
   always_comb begin
      head_age  = req_ff.now_ms - cell_q[0].stamp;
      head_live = cell_q[0].used && (head_age < ttl_ff);
      head_exp  = cell_q[0].used && !head_live;
      head_hit  = cell_q[0].hash == key_hash;
      scan_last = scan_idx_ff == IDX_W'(SLOTS - 1);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scan_idx_ff  <= '0;
         seen_ff      <= 1'b0;
         found_exp_ff <= 1'b0;
         have_free_ff <= 1'b0;
         old_age_ff   <= '0;
         old_idx_ff   <= '0;
         exp_idx_ff   <= '0;
         free_idx_ff  <= '0;
         live_cnt_ff  <= '0;
      end else if (scan_en) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (head_live) begin
            live_cnt_ff <= live_cnt_ff + CNT_W'(1);
            if (head_hit) begin
               seen_ff <= 1'b1;
            end
            // Later slots win ties for the oldest live entry.
            if (head_age >= old_age_ff) begin
               old_age_ff <= head_age;
               old_idx_ff <= scan_idx_ff;
            end
         end
         if (!found_exp_ff && head_exp && head_hit) begin
            found_exp_ff <= 1'b1;
            exp_idx_ff   <= scan_idx_ff;
         end
         if (!have_free_ff && !head_live) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= scan_idx_ff;
         end
      end
   end

   // Victim: an expired slot with the same hash, else the first free or
   // expired slot, else the oldest live slot.
   always_comb begin
      do_write    = is_mark && !seen_ff;
      victim_live = !found_exp_ff && !have_free_ff;
      if (found_exp_ff) begin
         victim = exp_idx_ff;
      end else if (have_free_ff) begin
         victim = free_idx_ff;
      end else begin
         victim = old_idx_ff;
      end
      write_entry.used  = 1'b1;
      write_entry.hash  = key_hash;
      write_entry.stamp = req_ff.now_ms;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      assign cell_ctrl[i].shift = scan_en;
      assign cell_ctrl[i].clear = commit_en && is_clear;
      assign cell_ctrl[i].load  = commit_en && do_write && (victim == IDX_W'(i));

      dht_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[i]),
         .shift_in (cell_q[(i + 1) % SLOTS]),
         .write_in (write_entry),
         .entry_out(cell_q[i])
      );
   end

   // Live count after the operation. A fresh entry is live unless the TTL is
   // zero, and it displaces a live entry only when the table was full.
   always_comb begin
      if (is_clear) begin
         count_wide = '0;
      end else if (do_write) begin
         count_wide = 9'(live_cnt_ff) - 9'(victim_live) + 9'(ttl_ff != 32'd0);
      end else begin
         count_wide = 9'(live_cnt_ff);
      end
      rsp_next.seen       = seen_ff;
      rsp_next.live_count = (count_wide > 9'(COUNT_MAX)) ? 6'(COUNT_MAX) : count_wide[5:0];
      rsp_next.key_hash   = key_hash;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> bench/dedup_table_checker.sv
module dedup_table_checker
   import dht_pkg::*;
#(
   parameter int unsigned SLOTS      = 32,
   parameter int unsigned CALL_BYTES = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire dht_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dht_rsp_type rsp_data,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   logic [31:0] tbl_hash [SLOTS];
   logic [31:0] tbl_stamp [SLOTS];
   logic        tbl_used [SLOTS];
   logic [31:0] ttl;
   dht_rsp_type expected_q [$];

   assign pending = expected_q.size();

   function automatic logic [31:0] fnv_key_hash(dht_req_type r);
      logic [31:0] h;
      logic [7:0]  b;
      logic        ended;
      h = FNV_BASIS;
      ended = 1'b0;
      for (int i = 0; i < CALL_BYTES; i++) begin
         b = (i < 5) ? r.call_sign[8*i +: 8] : 8'h00;
         if (b == 8'h00) begin
            ended = 1'b1;
         end
         h = (h ^ {24'h0, (ended ? PAD_BYTE : b)}) * FNV_PRIME;
      end
      h = (h ^ {24'h0, r.message_id[7:0]}) * FNV_PRIME;
      h = (h ^ {24'h0, r.message_id[15:8]}) * FNV_PRIME;
      h = (h ^ {24'h0, r.fragment_index}) * FNV_PRIME;
      return h;
   endfunction

   function automatic logic is_live(int i, logic [31:0] now);
      logic [31:0] age;
      age = now - tbl_stamp[i];
      return tbl_used[i] && (age < ttl);
   endfunction

   // Applies one item to the shadow table and returns its result.
   function automatic dht_rsp_type apply_item(dht_req_type r);
      dht_rsp_type res;
      logic [31:0] h, age, old_age;
      logic        have_free, found_exp;
      int          free_idx, old_idx, victim, cnt;
      h = fnv_key_hash(r);
      res = '0;
      res.key_hash = h;
      if (r.mode == MODE_CLEAR) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_hash[i] = '0;
            tbl_stamp[i] = '0;
            tbl_used[i] = 1'b0;
         end
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (is_live(i, r.now_ms) && tbl_hash[i] == h) begin
               res.seen = 1'b1;
            end
         end
         if (r.mode == MODE_MARK && !res.seen) begin
            have_free = 1'b0;
            found_exp = 1'b0;
            free_idx = 0;
            old_idx = 0;
            old_age = '0;
            victim = 0;
            for (int i = 0; i < SLOTS && !found_exp; i++) begin
               age = r.now_ms - tbl_stamp[i];
               if (!tbl_used[i] || age >= ttl) begin
                  if (tbl_used[i] && tbl_hash[i] == h) begin
                     found_exp = 1'b1;
                     victim = i;
                  end else if (!have_free) begin
                     have_free = 1'b1;
                     free_idx = i;
                  end
               end else if (age >= old_age) begin
                  old_age = age;
                  old_idx = i;
               end
            end
            if (!found_exp) begin
               victim = have_free ? free_idx : old_idx;
            end
            tbl_hash[victim] = h;
            tbl_stamp[victim] = r.now_ms;
            tbl_used[victim] = 1'b1;
         end
      end
      cnt = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (is_live(i, r.now_ms)) begin
            cnt++;
         end
      end
      if (cnt > COUNT_MAX) begin
         cnt = COUNT_MAX;
      end
      res.live_count = cnt[5:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      dht_rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_hash[i] <= '0;
            tbl_stamp[i] <= '0;
            tbl_used[i] <= 1'b0;
         end
         ttl <= TTL_RESET;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            ttl = csr_wdata;
         end
         if (req_valid && req_ready) begin
            expected_q.push_back(apply_item(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item", 32'(rsp_data), 32'h0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.seen !== want.seen) begin
                  report_mismatch("seen", 32'(rsp_data.seen), 32'(want.seen));
               end
               if (rsp_data.live_count !== want.live_count) begin
                  report_mismatch("live_count", 32'(rsp_data.live_count),
                                  32'(want.live_count));
               end
               if (rsp_data.key_hash !== want.key_hash) begin
                  report_mismatch("key_hash", rsp_data.key_hash, want.key_hash);
               end
            end
         end
      end
   end

endmodule

>>> bench/packet_dedup_hash_ttl_table_tb.sv
module packet_dedup_hash_ttl_table_tb;
   import dht_pkg::*;

   localparam int LATENCY   = 60;
   localparam int CYCLE_CAP = 1500000;

   // The mode value that has no defined meaning.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   dht_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   dht_rsp_type rsp_data;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          cycle_count;

   // Shared timeline and a small pool of keys, so that repeats and refreshes happen
   // often enough for the table to see hits, expiries and evictions.
   logic [31:0] clock_ms;
   dht_req_type key_pool [16];

   packet_dedup_hash_ttl_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   dedup_table_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The cycle counter is the only timeout; it ends the run when it trips.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // The receiver stalls in a pattern that changes its mood now and then, with
   // stretches of always ready among them.
   int stall_mood;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         stall_mood <= $urandom_range(0, 3);
      end
      case (stall_mood)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ~rsp_ready;
      endcase
   end

   // Sends one item, holding it until the block takes it, then drops valid and waits
   // for the next clock edge before it returns.
   task automatic send_item(dht_req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // Configuration only changes once the block is empty and settled.
   task automatic write_ttl(logic [31:0] value);
      while (pending != 0) begin
         @(posedge clock);
      end
      idle_cycles(LATENCY);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic dht_req_type make_item(logic [1:0] mode, logic [39:0] call,
                                             logic [15:0] id, logic [7:0] frag,
                                             logic [31:0] now);
      dht_req_type r;
      r.mode = mode;
      r.call_sign = call;
      r.message_id = id;
      r.fragment_index = frag;
      r.now_ms = now;
      return r;
   endfunction

   // Random call signs: random bytes, sometimes cut short by a zero byte.
   function automatic logic [39:0] random_call();
      logic [39:0] c;
      c = 40'({$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) begin
         c[8*$urandom_range(0, 4) +: 8] = 8'h00;
      end
      return c;
   endfunction

   // One random item drawn mostly from the key pool, with time moving forward by
   // amounts scaled to the current TTL so entries age out at a useful rate.
   task automatic send_random(logic [31:0] step_max);
      dht_req_type r;
      int          pick;
      logic [1:0]  mode;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         mode = MODE_CLEAR;
      end else if (pick < 4) begin
         mode = MODE_SPARE;
      end else if (pick < 25) begin
         mode = MODE_PEEK;
      end else begin
         mode = MODE_MARK;
      end
      clock_ms = clock_ms + $urandom_range(0, step_max);
      if ($urandom_range(0, 3) == 0) begin
         r = make_item(mode, random_call(), 16'($urandom), 8'($urandom), clock_ms);
         key_pool[$urandom_range(0, 15)] = r;
      end else begin
         r = key_pool[$urandom_range(0, 15)];
         r.mode = mode;
         r.now_ms = clock_ms;
      end
      if ($urandom_range(0, 49) == 0) begin
         r.now_ms = $urandom;
      end
      send_item(r);
   endtask

   task automatic random_phase(int count, logic [31:0] step_max);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_random(step_max);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            idle_cycles($urandom_range(1, 80));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      cycle_count = 0;
      stall_mood = 0;
      clock_ms = '0;
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = make_item(MODE_MARK, random_call(), 16'($urandom), 8'($urandom),
                                 '0);
      end
      idle_cycles(3);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset TTL: field extremes, every mode, a repeat hit,
      // a short call sign, the undefined mode, expiry and clear.
      send_item(make_item(MODE_MARK, 40'h0, 16'h0, 8'h0, 32'h0));
      send_item(make_item(MODE_MARK, 40'h0, 16'h0, 8'h0, 32'h1));
      send_item(make_item(MODE_PEEK, 40'hFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
      send_item(make_item(MODE_MARK, 40'hFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
      send_item(make_item(MODE_MARK, 40'hFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 32'd100));
      send_item(make_item(MODE_MARK, 40'h42_00_43_41_4B, 16'h1234, 8'h01, 32'd200));
      send_item(make_item(MODE_PEEK, 40'h00_00_43_41_4B, 16'h1234, 8'h01, 32'd300));
      send_item(make_item(MODE_SPARE, 40'h55_55_55_55_55, 16'hAAAA, 8'h55, 32'd400));
      send_item(make_item(MODE_PEEK, 40'h42_00_43_41_4B, 16'h1234, 8'h01, 32'd30199));
      send_item(make_item(MODE_PEEK, 40'h42_00_43_41_4B, 16'h1234, 8'h01, 32'd30200));
      send_item(make_item(MODE_MARK, 40'h42_00_43_41_4B, 16'h1234, 8'h01, 32'd30200));
      send_item(make_item(MODE_CLEAR, 40'hAA_AA_AA_AA_AA, 16'h5555, 8'hAA, 32'd30300));
      send_item(make_item(MODE_PEEK, 40'h42_00_43_41_4B, 16'h1234, 8'h01, 32'd30301));
      // Fill past the table size so the oldest live entry gets evicted.
      for (int i = 0; i < 36; i++) begin
         send_item(make_item(MODE_MARK, 40'h31_30_4E_52_57, 16'(i), 8'h07,
                             32'd40000 + 32'(i / 2)));
      end

      // Zero TTL: nothing is ever live.
      write_ttl(32'd0);
      send_item(make_item(MODE_MARK, 40'h41, 16'h1, 8'h1, 32'd5));
      send_item(make_item(MODE_MARK, 40'h41, 16'h1, 8'h1, 32'd5));
      random_phase(150, 32'd50);

      // Smallest nonzero TTL, then ordinary ones, then the largest.
      write_ttl(32'd1);
      random_phase(250, 32'd2);
      write_ttl(32'd500);
      random_phase(500, 32'd60);
      write_ttl(TTL_RESET);
      random_phase(400, 32'd4000);
      write_ttl(32'hFFFF_FFFF);
      random_phase(400, 32'h0100_0000);

      while (pending != 0) begin
         @(posedge clock);
      end
      idle_cycles(LATENCY);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
